@@ rtl/qse_pkg.sv @@
// qse_pkg: shared types, microcode word layout and step addresses for the
// quicksort engine. No dependencies; used by qse_sequencer and quicksort_engine.
package qse_pkg;

    // Default configuration
    localparam int MAX_KEYS_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // Port words
    typedef struct packed {
        logic [31:0] key_in;
        logic        last_in;
    } item_t;

    typedef struct packed {
        logic [31:0] key_out;
        logic        last_out;
    } result_t;

    // Microprogram addresses
    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_IDLE  = 5'd0;
    localparam upc_t UPC_CHK   = 5'd1;
    localparam upc_t UPC_SEED  = 5'd2;
    localparam upc_t UPC_POP   = 5'd3;
    localparam upc_t UPC_RANGE = 5'd4;
    localparam upc_t UPC_RDPIV = 5'd5;
    localparam upc_t UPC_PIV   = 5'd6;
    localparam upc_t UPC_LOOP  = 5'd7;
    localparam upc_t UPC_CMP   = 5'd8;
    localparam upc_t UPC_SW1   = 5'd9;
    localparam upc_t UPC_SW2   = 5'd10;
    localparam upc_t UPC_FIN   = 5'd11;
    localparam upc_t UPC_FIN1  = 5'd12;
    localparam upc_t UPC_FIN2  = 5'd13;
    localparam upc_t UPC_PUSHR = 5'd14;
    localparam upc_t UPC_AGAIN = 5'd15;
    localparam upc_t UPC_OUT0  = 5'd16;
    localparam upc_t UPC_OUT   = 5'd17;
    localparam upc_t UPC_DONE  = 5'd18;

    // Key store read address select
    typedef enum logic [1:0] {
        RA_J,
        RA_I,
        RA_HI,
        RA_K
    } rd_sel_t;

    // Key store write select
    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_I_KJ,
        WR_J_TMP,
        WR_I_PIV,
        WR_HI_TMP
    } wr_sel_t;

    // Datapath register operation
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH_ALL,
        OP_POP,
        OP_RANGE,
        OP_PIVOT,
        OP_CMP,
        OP_TMP,
        OP_STEP,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_KCLR,
        OP_EMIT,
        OP_DONE
    } dp_op_t;

    // Jump condition; jump taken when true, else fall through
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_GO,
        C_CNT_LT2,
        C_J_GE_HI,
        C_NOT_LESS,
        C_SP_NZ,
        C_MORE
    } cond_t;

    typedef struct packed {
        logic    idle;
        rd_sel_t rd;
        wr_sel_t wr;
        dp_op_t  op;
        cond_t   cond;
        upc_t    target;
    } ucode_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic go;
        logic cnt_lt2;
        logic j_ge_hi;
        logic not_less;
        logic sp_nz;
        logic more;
    } flags_t;

endpackage

@@ rtl/qse_sequencer.sv @@
// qse_sequencer: step counter, control store and jump logic for the quicksort engine.
// Depends on qse_pkg.
module qse_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  qse_pkg::flags_t flags,
    output qse_pkg::ucode_t uc
);

    qse_pkg::upc_t upc_reg;
    qse_pkg::upc_t upc_next;
    logic          take;

    function automatic qse_pkg::ucode_t rom(input qse_pkg::upc_t a);
        qse_pkg::ucode_t w;
        begin
            w = '{idle: 1'b0, rd: qse_pkg::RA_J, wr: qse_pkg::WR_NONE,
                  op: qse_pkg::OP_NONE, cond: qse_pkg::C_NEXT,
                  target: qse_pkg::UPC_IDLE};
            unique case (a)
                qse_pkg::UPC_IDLE:
                begin
                    w.idle   = 1'b1;
                    w.wr     = qse_pkg::WR_LOAD;
                    w.cond   = qse_pkg::C_NOT_GO;
                    w.target = qse_pkg::UPC_IDLE;
                end
                qse_pkg::UPC_CHK:
                begin
                    w.cond   = qse_pkg::C_CNT_LT2;
                    w.target = qse_pkg::UPC_OUT0;
                end
                qse_pkg::UPC_SEED:  w.op = qse_pkg::OP_PUSH_ALL;
                qse_pkg::UPC_POP:   w.op = qse_pkg::OP_POP;
                qse_pkg::UPC_RANGE: w.op = qse_pkg::OP_RANGE;
                qse_pkg::UPC_RDPIV: w.rd = qse_pkg::RA_HI;
                qse_pkg::UPC_PIV:   w.op = qse_pkg::OP_PIVOT;
                qse_pkg::UPC_LOOP:
                begin
                    w.rd     = qse_pkg::RA_J;
                    w.cond   = qse_pkg::C_J_GE_HI;
                    w.target = qse_pkg::UPC_FIN;
                end
                qse_pkg::UPC_CMP:
                begin
                    w.rd     = qse_pkg::RA_I;
                    w.op     = qse_pkg::OP_CMP;
                    w.cond   = qse_pkg::C_NOT_LESS;
                    w.target = qse_pkg::UPC_LOOP;
                end
                qse_pkg::UPC_SW1:
                begin
                    w.op = qse_pkg::OP_TMP;
                    w.wr = qse_pkg::WR_I_KJ;
                end
                qse_pkg::UPC_SW2:
                begin
                    w.op     = qse_pkg::OP_STEP;
                    w.wr     = qse_pkg::WR_J_TMP;
                    w.cond   = qse_pkg::C_ALWAYS;
                    w.target = qse_pkg::UPC_LOOP;
                end
                qse_pkg::UPC_FIN:   w.rd = qse_pkg::RA_I;
                qse_pkg::UPC_FIN1:
                begin
                    w.op = qse_pkg::OP_TMP;
                    w.wr = qse_pkg::WR_I_PIV;
                end
                qse_pkg::UPC_FIN2:
                begin
                    w.op = qse_pkg::OP_PUSH_L;
                    w.wr = qse_pkg::WR_HI_TMP;
                end
                qse_pkg::UPC_PUSHR: w.op = qse_pkg::OP_PUSH_R;
                qse_pkg::UPC_AGAIN:
                begin
                    w.cond   = qse_pkg::C_SP_NZ;
                    w.target = qse_pkg::UPC_POP;
                end
                qse_pkg::UPC_OUT0:  w.op = qse_pkg::OP_KCLR;
                qse_pkg::UPC_OUT:
                begin
                    w.rd     = qse_pkg::RA_K;
                    w.op     = qse_pkg::OP_EMIT;
                    w.cond   = qse_pkg::C_MORE;
                    w.target = qse_pkg::UPC_OUT;
                end
                qse_pkg::UPC_DONE:
                begin
                    w.op     = qse_pkg::OP_DONE;
                    w.cond   = qse_pkg::C_ALWAYS;
                    w.target = qse_pkg::UPC_IDLE;
                end
                default:
                begin
                    w.cond   = qse_pkg::C_ALWAYS;
                    w.target = qse_pkg::UPC_IDLE;
                end
            endcase
            return w;
        end
    endfunction

    assign uc = rom(upc_reg);

    always_comb
    begin
        unique case (uc.cond)
            qse_pkg::C_NEXT:     take = 1'b0;
            qse_pkg::C_ALWAYS:   take = 1'b1;
            qse_pkg::C_NOT_GO:   take = !flags.go;
            qse_pkg::C_CNT_LT2:  take = flags.cnt_lt2;
            qse_pkg::C_J_GE_HI:  take = flags.j_ge_hi;
            qse_pkg::C_NOT_LESS: take = flags.not_less;
            qse_pkg::C_SP_NZ:    take = flags.sp_nz;
            qse_pkg::C_MORE:     take = flags.more;
            default:             take = 1'b1;
        endcase
        upc_next = take ? uc.target : upc_reg + qse_pkg::UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= qse_pkg::UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // step counter never leaves the program
    a_upc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= qse_pkg::UPC_DONE)
        else $error("step counter outside microprogram");

endmodule

@@ rtl/quicksort_engine.sv @@
// quicksort_engine: top level; key store, range stack and datapath under
// control of the microcoded sequencer. Depends on qse_pkg and qse_sequencer.
//
// Usage: keys are loaded one word per cycle (start high while busy is low);
// the word with last_in set closes the list and starts the sort. Keys beyond
// MAX_KEYS are dropped, though a dropped word with last_in still starts the
// sort. The list is sorted in place by quicksort with Lomuto partitioning
// (last element of each range is the pivot, pending ranges on a stack), then
// streamed out in ascending order, one word per cycle on result with
// result_strobe high for one cycle, last_out set on the final key. The
// receiver cannot stall: every strobed word must be taken. Ordering is
// unsigned or two's complement as set by the signed_order register
// (cfg_wr_en/cfg_wr_data); the user must see that it is written only while
// busy is low, as the block itself does not enforce this. The sort runs on
// one single-port-read key store. The partition loop reads each element of
// the range and swaps it forward when it is less than the pivot. Each
// partition also pops its range, fetches the pivot, exits the loop, does
// the final swap and pushes its subranges; the stack is seeded once per
// list. Sorting is slowest on already sorted input. busy falls in the cycle
// after the one that carries the final strobed word, and a new list may be
// loaded from then on.
module quicksort_engine #(
    parameter int MAX_KEYS  = qse_pkg::MAX_KEYS_DEF,
    parameter int KEY_WIDTH = qse_pkg::KEY_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  qse_pkg::item_t   item,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    output logic             result_strobe,
    output qse_pkg::result_t result
);

    localparam int IW = $clog2(MAX_KEYS);       // key index
    localparam int CW = $clog2(MAX_KEYS + 1);   // key count / stack pointer
    localparam int SW = 2 * IW;                 // stack entry {hi, lo}

    qse_pkg::ucode_t uc;
    qse_pkg::flags_t flags;

    // storage
    logic [KEY_WIDTH-1:0] key_mem [MAX_KEYS];
    logic [SW-1:0]        stack_mem [MAX_KEYS];
    logic [KEY_WIDTH-1:0] rdata_reg;
    logic [SW-1:0]        srdata_reg;

    // control state
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic          strobe_reg, strobe_next;
    logic          signed_order_reg;

    // datapath registers
    logic [IW-1:0]        lo_reg, lo_next;
    logic [IW-1:0]        hi_reg, hi_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [IW-1:0]        j_reg, j_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [KEY_WIDTH-1:0] pivot_reg, pivot_next;
    logic [KEY_WIDTH-1:0] kj_reg, kj_next;
    logic [KEY_WIDTH-1:0] tmp_reg, tmp_next;
    logic                 last_reg, last_next;

    // combinational datapath
    logic                  accept;
    logic                  full;
    logic                  less;
    logic                  need_l;
    logic                  need_r;
    logic [KEY_WIDTH+31:0] key_ext;
    logic [KEY_WIDTH+31:0] out_ext;
    logic [KEY_WIDTH-1:0]  load_key;
    logic [KEY_WIDTH-1:0]  sign_mask;
    logic [IW-1:0]         rd_addr;
    logic                  k_we;
    logic [IW-1:0]         k_waddr;
    logic [KEY_WIDTH-1:0]  k_wdata;
    logic                  s_we;
    logic [SW-1:0]         s_wdata;
    logic [IW-1:0]         s_raddr;

    qse_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uc    (uc)
    );

    assign accept = start && uc.idle;
    assign busy   = !uc.idle;
    assign full   = (cnt_reg == CW'(MAX_KEYS));

    // key_in is 32 bits; keep the low KEY_WIDTH bits, zero-extend if wider
    assign key_ext  = {{KEY_WIDTH{1'b0}}, item.key_in};
    assign load_key = key_ext[KEY_WIDTH-1:0];

    // signed order: flip the sign bit, then compare unsigned
    assign sign_mask = signed_order_reg ? {1'b1, {(KEY_WIDTH-1){1'b0}}} : '0;
    assign less      = (rdata_reg ^ sign_mask) < (pivot_reg ^ sign_mask);

    // partition index p is i_reg after the loop
    assign need_l = {1'b0, i_reg} > ({1'b0, lo_reg} + (IW+1)'(1));
    assign need_r = ({1'b0, i_reg} + (IW+1)'(1)) < {1'b0, hi_reg};

    assign flags.go       = accept && item.last_in;
    assign flags.cnt_lt2  = cnt_reg < CW'(2);
    assign flags.j_ge_hi  = j_reg >= hi_reg;
    assign flags.not_less = !less;
    assign flags.sp_nz    = sp_reg != '0;
    assign flags.more     = CW'(k_reg) != (cnt_reg - CW'(1));

    assign s_raddr = IW'(sp_reg - CW'(1));

    always_comb
    begin
        unique case (uc.rd)
            qse_pkg::RA_J:  rd_addr = j_reg;
            qse_pkg::RA_I:  rd_addr = i_reg;
            qse_pkg::RA_HI: rd_addr = hi_reg;
            qse_pkg::RA_K:  rd_addr = k_reg;
            default:        rd_addr = j_reg;
        endcase
    end

    // key store write port
    always_comb
    begin
        k_we    = 1'b0;
        k_waddr = i_reg;
        k_wdata = kj_reg;
        unique case (uc.wr)
            qse_pkg::WR_NONE: ;
            qse_pkg::WR_LOAD:
            begin
                k_we    = accept && !full;
                k_waddr = IW'(cnt_reg);
                k_wdata = load_key;
            end
            qse_pkg::WR_I_KJ:
            begin
                k_we = 1'b1;
            end
            qse_pkg::WR_J_TMP:
            begin
                k_we    = 1'b1;
                k_waddr = j_reg;
                k_wdata = tmp_reg;
            end
            qse_pkg::WR_I_PIV:
            begin
                k_we    = 1'b1;
                k_wdata = pivot_reg;
            end
            qse_pkg::WR_HI_TMP:
            begin
                k_we    = 1'b1;
                k_waddr = hi_reg;
                k_wdata = tmp_reg;
            end
            default: ;
        endcase
    end

    // register next values and range stack pushes
    always_comb
    begin
        cnt_next   = cnt_reg;
        sp_next    = sp_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        pivot_next = pivot_reg;
        kj_next    = kj_reg;
        tmp_next   = tmp_reg;
        last_next  = last_reg;
        s_we       = 1'b0;
        s_wdata    = {hi_reg, IW'(i_reg + IW'(1))};

        if (uc.wr == qse_pkg::WR_LOAD && accept && !full)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        unique case (uc.op)
            qse_pkg::OP_NONE: ;
            qse_pkg::OP_PUSH_ALL:
            begin
                s_we    = 1'b1;
                s_wdata = {IW'(cnt_reg - CW'(1)), IW'(0)};
                sp_next = CW'(1);
            end
            qse_pkg::OP_POP:
            begin
                sp_next = sp_reg - CW'(1);
            end
            qse_pkg::OP_RANGE:
            begin
                lo_next = srdata_reg[IW-1:0];
                hi_next = srdata_reg[SW-1:IW];
                i_next  = srdata_reg[IW-1:0];
                j_next  = srdata_reg[IW-1:0];
            end
            qse_pkg::OP_PIVOT:
            begin
                pivot_next = rdata_reg;
            end
            qse_pkg::OP_CMP:
            begin
                kj_next = rdata_reg;
                if (!less)
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            qse_pkg::OP_TMP:
            begin
                tmp_next = rdata_reg;
            end
            qse_pkg::OP_STEP:
            begin
                i_next = i_reg + IW'(1);
                j_next = j_reg + IW'(1);
            end
            qse_pkg::OP_PUSH_L:
            begin
                s_wdata = {IW'(i_reg - IW'(1)), lo_reg};
                if (need_l)
                begin
                    s_we    = 1'b1;
                    sp_next = sp_reg + CW'(1);
                end
            end
            qse_pkg::OP_PUSH_R:
            begin
                if (need_r)
                begin
                    s_we    = 1'b1;
                    sp_next = sp_reg + CW'(1);
                end
            end
            qse_pkg::OP_KCLR:
            begin
                k_next = '0;
            end
            qse_pkg::OP_EMIT:
            begin
                k_next    = k_reg + IW'(1);
                last_next = CW'(k_reg) == (cnt_reg - CW'(1));
            end
            qse_pkg::OP_DONE:
            begin
                cnt_next = '0;
            end
            default: ;
        endcase

        strobe_next = (uc.op == qse_pkg::OP_EMIT);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            sp_reg           <= '0;
            strobe_reg       <= 1'b0;
            signed_order_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            sp_reg     <= sp_next;
            strobe_reg <= strobe_next;
            if (cfg_wr_en)
            begin
                signed_order_reg <= cfg_wr_data;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        pivot_reg <= pivot_next;
        kj_reg    <= kj_next;
        tmp_reg   <= tmp_next;
        last_reg  <= last_next;
    end

    // key store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            key_mem[k_waddr] <= k_wdata;
        end
        rdata_reg <= key_mem[rd_addr];
    end

    // range stack: push at sp, read at sp-1 (registered)
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stack_mem[IW'(sp_reg)] <= s_wdata;
        end
        srdata_reg <= stack_mem[s_raddr];
    end

    // result word: registered read data lines up with the strobe
    assign out_ext         = {32'b0, rdata_reg};
    assign result.key_out  = out_ext[31:0];
    assign result.last_out = last_reg;
    assign result_strobe   = strobe_reg;

    // results only appear while the engine is busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> !uc.idle)
        else $error("result strobe while idle");

    // range stack drained between lists
    a_stack_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        uc.idle |-> (sp_reg == '0))
        else $error("range stack not empty when idle");

    // pending ranges are disjoint and at least two keys each
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(MAX_KEYS / 2))
        else $error("range stack deeper than possible");

    // store is emptied after the final word
    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |=> (cnt_reg == '0))
        else $error("key count not cleared after final word");

    // Lomuto invariant: store index never passes scan index
    a_i_le_j: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.op == qse_pkg::OP_CMP) |-> (i_reg <= j_reg))
        else $error("partition index past scan index");

endmodule
